// File: rtl/wbps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int SIG_BYTES   = 16;
	localparam int WIN_DEPTH   = MAX_PATTERN - 1;
	localparam int LEN_W       = 5;
	localparam int FILL_W      = $clog2(MAX_PATTERN);
	localparam int ADDR_W      = 48;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd3;

	typedef struct packed {
		logic [SIG_BYTES-1:0][7:0] sig;   // signature bytes, position 0 lowest
		logic [SIG_BYTES-1:0]      care;  // per-position compare enable
		logic [LEN_W-1:0]          len;   // saturated to MAX_PATTERN
	} cfg_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic [ADDR_W-1:0] byte_address;
		logic              scan_start;
		logic              region_start;
		logic              scan_end;
	} item_t;

	typedef struct packed {
		logic              valid;
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} result_t;

endpackage : wbps_pkg
`default_nettype wire

// File: rtl/wbps_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Configuration registers: signature bytes, care mask and pattern length.
// ----------------------------------------------------------------------------
module wbps_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output wbps_pkg::cfg_t                      cfg
);
	import wbps_pkg::*;

	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [SIG_BYTES-1:0]  care_q;
	logic [LEN_W-1:0]      len_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_wdata;
				REG_PATTERN_HIGH: pat_high_q <= cfg_wdata;
				REG_CARE_MASK:    care_q     <= cfg_wdata[SIG_BYTES-1:0];
				REG_PATTERN_LEN:  len_q      <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the length to the window span
	always_comb begin
		cfg.sig  = {pat_high_q, pat_low_q};
		cfg.care = care_q;
		if (len_q > LEN_W'(MAX_PATTERN)) begin
			cfg.len = LEN_W'(MAX_PATTERN);
		end else begin
			cfg.len = len_q;
		end
	end

endmodule : wbps_cfg_regs
`default_nettype wire

// File: rtl/wbps_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_core
// Byte window, fill count and found flag, with the parallel position compare.
// ----------------------------------------------------------------------------
module wbps_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wbps_pkg::cfg_t cfg,
	input  wire wbps_pkg::item_t item,
	input  wire logic           adv,
	output wbps_pkg::result_t   res
);
	import wbps_pkg::*;

	logic [WIN_DEPTH-1:0][7:0]   win_q;
	logic [FILL_W-1:0]           fill_q;
	logic                        found_q;

	logic [FILL_W-1:0]           fill_eff;
	logic                        found_eff;
	logic [MAX_PATTERN-1:0][7:0] seq;
	logic [MAX_PATTERN-1:0]      pos_ok;
	logic                        hit;
	logic [FILL_W-1:0]           sel;

	// scan start resets the fill count and the found flag; region start only the fill count
	always_comb begin
		fill_eff  = (item.scan_start || item.region_start) ? '0 : fill_q;
		found_eff = item.scan_start ? 1'b0 : found_q;
	end

	// newest byte first, then the window from most recent back
	always_comb begin
		seq[0] = item.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			seq[k] = win_q[k-1];
		end
	end

	// compare every position against its byte in parallel
	always_comb begin
		sel = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			sel = FILL_W'(cfg.len - LEN_W'(1) - LEN_W'(i));
			pos_ok[i] = (LEN_W'(i) >= cfg.len) || (i >= SIG_BYTES) ||
				!cfg.care[i] || (seq[sel] == cfg.sig[i]);
		end
		hit = (cfg.len != '0) && ((LEN_W'(fill_eff) + LEN_W'(1)) >= cfg.len) && (&pos_ok);
	end

	// one result per scan: the match, or not found at scan end
	always_comb begin
		res.valid         = !found_eff && (hit || item.scan_end);
		res.found         = hit;
		res.match_address = hit ? (item.byte_address - ADDR_W'(cfg.len - LEN_W'(1))) : '0;
	end

	// advance window, fill and found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			fill_q  <= '0;
			found_q <= 1'b0;
		end else if (adv) begin
			if (found_eff) begin
				fill_q  <= fill_eff;
				found_q <= 1'b1;
			end else begin
				win_q <= {win_q[WIN_DEPTH-2:0], item.data_byte};
				if (fill_eff < FILL_W'(WIN_DEPTH)) begin
					fill_q <= fill_eff + FILL_W'(1);
				end else begin
					fill_q <= fill_eff;
				end
				found_q <= hit || item.scan_end;
			end
		end
	end

endmodule : wbps_core
`default_nettype wire

// File: rtl/wbps_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_out_reg
// Result register on the master side; loads while the held word drains.
// ----------------------------------------------------------------------------
module wbps_out_reg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire wbps_pkg::result_t           res,
	output logic                             room,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [wbps_pkg::ADDR_W-1:0]      m_tdata,
	output logic                             m_tuser
);
	import wbps_pkg::*;

	logic              valid_q;
	logic              found_q;
	logic [ADDR_W-1:0] addr_q;

	assign room = !valid_q || m_tready;

	// hold the valid flag until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= res.found;
			addr_q  <= res.match_address;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = addr_q;
	assign m_tuser  = found_q;

endmodule : wbps_out_reg
`default_nettype wire

// File: rtl/wildcard_byte_pattern_scanner_unit.sv
// Path: a byte accepted into the input register is compared in the core and,
// when it yields a result, loaded into the result register that offers it.
// Throughput: one byte per cycle; the input stalls only while the input
// register's byte yields a result and the held result word is not being taken.
// Reset (arst_n low) clears the configuration, window, fill count,
// found flag and both valid flags at once.
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Searches a byte stream for a wildcard signature and reports the first match.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [55:0]                     s_tdata,  // data_byte, byte_address
	input  wire logic [1:0]                      s_tuser,  // scan_start, region_start
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [wbps_pkg::ADDR_W-1:0]          m_tdata,  // match_address
	output logic                                 m_tuser   // found
);
	import wbps_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	logic    room;
	logic    adv;
	logic    load;

	wbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1 moves on unless its result finds the result register full
	assign adv      = valid_s1 && (!res.valid || room);
	assign load     = adv && res.valid;
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte    <= s_tdata[7:0];
			item_s1.byte_address <= s_tdata[55:8];
			item_s1.scan_start   <= s_tuser[0];
			item_s1.region_start <= s_tuser[1];
			item_s1.scan_end     <= s_tlast;
		end
	end

	wbps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv),
		.res    (res)
	);

	wbps_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule : wildcard_byte_pattern_scanner_unit
`default_nettype wire

// File: rtl/wbps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module wbps_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [wbps_pkg::ADDR_W-1:0]     m_tdata,
	input wire logic                            m_tuser
);

	// a stalled result word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a not-found report carries a zero address
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found report with non-zero address");

	// a new result word follows an accepted byte, an input stall or an earlier word
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || !$past(s_tready, 2)
			|| $past(m_tvalid, 2))
		else $error("result without a preceding input byte");

	// a stalled result word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

endmodule : wbps_checker

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);
`default_nettype wire

// File: tb/tb_wildcard_byte_pattern_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner_unit
// Self-checking bench for the wildcard byte pattern scanner. Byte words are
// streamed in with scan and region marks. A local model of the signature
// search predicts each match or not-found report, and every result word is
// compared against it in order. The receiver stalls; the sender inserts gaps.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import wbps_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 3;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLDOFF_LEN   = 200;
	localparam int PHASE_BYTES   = 470;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		bit                found;
		logic [ADDR_W-1:0] match_address;
	} match_report_t;

	// DUT connections
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [55:0]           s_tdata;   // data_byte, byte_address
	logic [1:0]            s_tuser;   // scan_start, region_start
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ADDR_W-1:0]     m_tdata;   // match_address
	logic                  m_tuser;   // found

	// signature registers as the block should hold them
	logic [63:0]        sig_low_bytes;
	logic [63:0]        sig_high_bytes;
	logic [15:0]        sig_care;
	logic [LEN_W-1:0]   sig_length;

	// search state of the model
	logic [7:0]         recent_bytes [MAX_PATTERN];
	int unsigned        window_fill;
	bit                 scan_done;

	match_report_t      pending_reports [$];
	match_report_t      head_report;

	int send_idle_pct;
	int recv_idle_pct;
	int holdoff_request;
	int holdoff_left;
	int stall_cycles;
	int failures;
	int words_sent;
	int scanned_bytes;
	int results_seen;
	int scans_sent;
	int settings_used;
	bit in_reset;

	wildcard_byte_pattern_scanner_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// free-running clock
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("mismatch %0d: %s", failures, msg);
	endfunction

	function automatic logic [7:0] signature_byte(input int unsigned pos);
		if (pos < 8)
			return sig_low_bytes[8*pos +: 8];
		return sig_high_bytes[8*(pos-8) +: 8];
	endfunction

	function automatic int unsigned active_length();
		return (sig_length > MAX_PATTERN) ? MAX_PATTERN : sig_length;
	endfunction

	// append a report behind the ones already expected
	function automatic void queue_report(input match_report_t rep);
		pending_reports.insert(pending_reports.size(), rep);
	endfunction

	// advance the search by one byte and queue any report it causes
	function automatic void predict_scan(input item_t it);
		int unsigned len;
		bit hit;
		logic [7:0] cand;
		match_report_t rep;
		if (it.scan_start) begin
			scan_done = 1'b0;
			window_fill = 0;
		end
		if (it.region_start)
			window_fill = 0;
		if (scan_done)
			return;
		scanned_bytes++;
		len = active_length();
		hit = (len > 0) && (window_fill + 1 >= len);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (hit && i < len) begin
				cand = (i == len - 1) ? it.data_byte : recent_bytes[len - 2 - i];
				if (sig_care[i] && cand != signature_byte(i))
					hit = 1'b0;
			end
		end
		for (int k = MAX_PATTERN - 1; k > 0; k--)
			recent_bytes[k] = recent_bytes[k-1];
		recent_bytes[0] = it.data_byte;
		if (window_fill < MAX_PATTERN - 1)
			window_fill++;
		if (hit) begin
			rep.found = 1'b1;
			rep.match_address = it.byte_address - ADDR_W'(len - 1);
			queue_report(rep);
			scan_done = 1'b1;
		end else if (it.scan_end) begin
			rep.found = 1'b0;
			rep.match_address = '0;
			queue_report(rep);
			scan_done = 1'b1;
		end
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.byte_address, it.data_byte};
		s_tuser  <= {it.region_start, it.scan_start};
		s_tlast  <= it.scan_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_scan(it);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
			input bit s_start, input bit r_start, input bit s_end);
		item_t it;
		it.data_byte    = data;
		it.byte_address = addr;
		it.scan_start   = s_start;
		it.region_start = r_start;
		it.scan_end     = s_end;
		send_word(it);
	endtask

	// stop offering and wait for every outstanding report, then let the pipe settle
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		case (idx)
			REG_PATTERN_LOW:  sig_low_bytes  = value;
			REG_PATTERN_HIGH: sig_high_bytes = value;
			REG_CARE_MASK:    sig_care       = value[15:0];
			REG_PATTERN_LEN:  sig_length     = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// load a full signature setting; only called while the block is idle
	task automatic load_signature(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] care, input logic [LEN_W-1:0] len);
		drain_reports();
		write_register(REG_PATTERN_LOW, lo);
		write_register(REG_PATTERN_HIGH, hi);
		write_register(REG_CARE_MASK, CFG_DATA_W'(care));
		write_register(REG_PATTERN_LEN, CFG_DATA_W'(len));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		if (!in_reset && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected result found=%0b addr=%h",
					m_tuser, m_tdata));
			end else begin
				head_report = pending_reports.pop_front();
				if (m_tuser !== head_report.found ||
						m_tdata !== head_report.match_address)
					note_failure($sformatf(
						"result %0d: expected found=%0b addr=%h, got found=%0b addr=%h",
						results_seen, head_report.found, head_report.match_address,
						m_tuser, m_tdata));
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (holdoff_request > 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (in_reset) begin
			m_tready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: give up when no word moves on either side for too long
	always @(posedge clk) begin
		if (in_reset || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without progress", stall_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// reset registers: empty pattern; bytes before any scan start are searched
	task automatic test_unconfigured_scan();
		send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'h00, 48'h0000_0000_0000, 1'b0, 1'b0, 1'b1);
	endtask

	// wildcard in the middle, match on the scan end byte, address wrap,
	// then a byte after the result is ignored
	task automatic test_wildcard_wrap();
		load_signature(64'h0000_0000_00FF_A500, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0005, 5'd3);
		send_byte(8'h00, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0);
		send_byte(8'h5A, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'hFF, 48'h0000_0000_0000, 1'b0, 1'b0, 1'b1);
		send_byte(8'hFF, 48'h0000_0000_0001, 1'b0, 1'b0, 1'b1);
	endtask

	// a region start in the middle breaks the match; bytes after not-found drop
	task automatic test_region_break();
		send_byte(8'h00, 48'h0000_0000_0100, 1'b1, 1'b1, 1'b0);
		send_byte(8'h5A, 48'h0000_0000_5000, 1'b0, 1'b1, 1'b0);
		send_byte(8'hFF, 48'h0000_0000_5001, 1'b0, 1'b0, 1'b0);
		send_byte(8'h00, 48'h0000_0000_5002, 1'b0, 1'b0, 1'b1);
		send_byte(8'h00, 48'h0000_0000_5003, 1'b0, 1'b0, 1'b0);
	endtask

	// all positions wildcard: match once enough bytes have arrived
	task automatic test_all_wildcard();
		load_signature(64'h0, 64'h0, 16'h0000, 5'd2);
		send_byte(8'h33, 48'h0000_0000_0010, 1'b1, 1'b1, 1'b0);
		send_byte(8'h44, 48'h0000_0000_0011, 1'b0, 1'b0, 1'b0);
	endtask

	// length register above the maximum saturates to the full signature
	task automatic test_length_saturation();
		load_signature(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'hFFFF, 5'd31);
		for (int i = 0; i < MAX_PATTERN; i++)
			send_byte(signature_byte(i), ADDR_W'(48'h8000_0000_0000 + i),
				i == 0, i == 0, 1'b0);
	endtask

	// hold the result side off while bytes keep coming, then pause the sender
	task automatic test_backpressure();
		load_signature(64'h0, 64'h0, 16'h0000, 5'd1);
		send_idle_pct = 0;
		holdoff_request = HOLDOFF_LEN;
		for (int i = 0; i < 40; i++)
			send_byte(8'($urandom), ADDR_W'({$urandom, $urandom}), 1'b1, 1'b1, 1'b0);
		drain_reports();
	endtask

	// pick a new signature setting, biased towards the extremes
	task automatic pick_signature();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] care;
		logic [LEN_W-1:0] len;
		int pick;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 8)       lo = '0;
		else if (pick < 16) lo = '1;
		pick = $urandom_range(99);
		if (pick < 8)       hi = '0;
		else if (pick < 16) hi = '1;
		pick = $urandom_range(99);
		if (pick < 15)      care = 16'h0000;
		else if (pick < 45) care = 16'hFFFF;
		else                care = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)       len = 5'd0;
		else if (pick < 16) len = LEN_W'($urandom_range(17, 31));
		else if (pick < 26) len = 5'd16;
		else if (pick < 34) len = 5'd1;
		else                len = LEN_W'($urandom_range(2, 15));
		load_signature(lo, hi, care, len);
	endtask

	// one scan: random bytes, often carrying the signature, a few region jumps
	task automatic send_random_scan();
		item_t it;
		int n;
		int len;
		int pos;
		logic [ADDR_W-1:0] addr;
		n = $urandom_range(4, 40);
		len = active_length();
		pos = n;
		if (len > 0 && len <= n && $urandom_range(99) < 65)
			pos = $urandom_range(0, n - len);
		addr = ADDR_W'({$urandom, $urandom});
		for (int j = 0; j < n; j++) begin
			it.data_byte    = 8'($urandom);
			it.scan_start   = (j == 0);
			it.region_start = (j == 0) || ($urandom_range(99) < 4);
			it.scan_end     = (j == n - 1);
			if (j >= pos && j < pos + len && sig_care[j - pos])
				it.data_byte = signature_byte(j - pos);
			if (it.region_start && j > 0)
				addr = ADDR_W'({$urandom, $urandom});
			// break the framing now and then
			if ($urandom_range(99) < 5) begin
				it.scan_start   = 1'($urandom_range(1));
				it.region_start = 1'($urandom_range(1));
				it.scan_end     = 1'($urandom_range(1));
			end
			it.byte_address = addr;
			send_word(it);
			addr++;
		end
		scans_sent++;
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int goal;
		goal = words_sent + PHASE_BYTES;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (words_sent < goal) begin
			pick_signature();
			repeat ($urandom_range(3, 10)) send_random_scan();
		end
	endtask

	initial begin
		in_reset        = 1'b1;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = '0;
		s_tlast         = 1'b0;
		m_tready        = 1'b0;
		sig_low_bytes   = '0;
		sig_high_bytes  = '0;
		sig_care        = '0;
		sig_length      = '0;
		window_fill     = 0;
		scan_done       = 1'b0;
		failures        = 0;
		words_sent      = 0;
		scanned_bytes   = 0;
		results_seen    = 0;
		scans_sent      = 0;
		settings_used   = 0;
		holdoff_request = 0;
		holdoff_left    = 0;
		stall_cycles    = 0;
		send_idle_pct   = 37;
		recv_idle_pct   = 64;
		foreach (recent_bytes[i])
			recent_bytes[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n   = 1'b1;
		in_reset = 1'b0;
		@(negedge clk);

		test_unconfigured_scan();
		test_wildcard_wrap();
		test_region_break();
		test_all_wildcard();
		test_length_saturation();
		test_backpressure();
		test_random_traffic(37, 64);
		test_random_traffic(64, 37);
		test_random_traffic(0, 0);
		drain_reports();

		if (pending_reports.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_reports.size()));
		$display("covered %0d words (%0d searched) in %0d random scans", words_sent,
			scanned_bytes, scans_sent);
		$display("%0d signature settings, %0d results checked, %0d failures",
			settings_used, results_seen, failures);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule : tb_wildcard_byte_pattern_scanner_unit

// File: files.f
rtl/wbps_pkg.sv
rtl/wbps_cfg_regs.sv
rtl/wbps_core.sv
rtl/wbps_out_reg.sv
rtl/wildcard_byte_pattern_scanner_unit.sv
rtl/wbps_checker.sv
tb/tb_wildcard_byte_pattern_scanner_unit.sv
